/* src/krt_pkg.sv */
// Shared types, widths and codes for the keyed record table.
package krt_pkg;

  localparam int KIND_W          = 2;
  localparam int KEY_W           = 32;
  localparam int VAL_W           = 32;
  localparam int SLOT_W          = 6;
  localparam int TABLE_DEPTH_DEF = 64;

  typedef logic [KIND_W-1:0] kind_t;

  // Request kinds; the unused code behaves as a search.
  localparam kind_t KIND_INSERT = 2'd0;
  localparam kind_t KIND_SEARCH = 2'd1;
  localparam kind_t KIND_UPDATE = 2'd2;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EXISTS  = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

endpackage

/* src/krt_if.sv */
// Request and result channel interfaces of the keyed record table.
interface krt_req_if;
  logic                               valid;
  logic                               ready;
  krt_pkg::kind_t                     kind;
  logic signed [krt_pkg::KEY_W-1:0]   part_key;
  logic signed [krt_pkg::VAL_W-1:0]   new_price;
  logic signed [krt_pkg::VAL_W-1:0]   qty_value;

  modport source (output valid, kind, part_key, new_price, qty_value, input ready);
  modport sink   (input valid, kind, part_key, new_price, qty_value, output ready);
endinterface

interface krt_rsp_if;
  logic                               valid;
  logic                               ready;
  krt_pkg::status_t                   status;
  logic [krt_pkg::SLOT_W-1:0]         slot;
  logic signed [krt_pkg::VAL_W-1:0]   found_price;
  logic signed [krt_pkg::VAL_W-1:0]   found_qty;

  modport source (output valid, status, slot, found_price, found_qty, input ready);
  modport sink   (input valid, status, slot, found_price, found_qty, output ready);
endinterface

/* src/keyed_record_table.sv */
// Keyed record table: linear-search part table with insert, search and update.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-----------------------------------------
//  in_ch   | in  | valid/ready        | kind, part_key, new_price, qty_value
//  out_ch  | out | valid/ready        | status, slot, found_price, found_qty
//
// Timing: a hit stops the scan early, and an update passes through a write-back
// state. The key memory's single read port sets the pace: the scan reads one key
// per cycle.
// Reset clears only the fill count and control; the memories need no clearing.
// One item is worked at a time; a finished result sits in the output register
// while the next item is taken, and a stalled output holds the following one.
module keyed_record_table #(
  parameter int TABLE_DEPTH = krt_pkg::TABLE_DEPTH_DEF
) (
  input logic        clk,
  input logic        rst_n,
  krt_req_if.sink    in_ch,
  krt_rsp_if.source  out_ch
);

  localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int VAL_W  = krt_pkg::VAL_W;
  localparam int KEY_W  = krt_pkg::KEY_W;
  localparam int SLOT_W = krt_pkg::SLOT_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_UPD  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  // Add a signed change and clamp to the 32-bit signed range.
  function automatic logic signed [VAL_W-1:0] sat_add(
    input logic signed [VAL_W-1:0] a,
    input logic signed [VAL_W-1:0] b
  );
    logic signed [VAL_W:0] sum;
    logic signed [VAL_W-1:0] res;
    sum = {a[VAL_W-1], a} + {b[VAL_W-1], b};
    if (sum[VAL_W] != sum[VAL_W-1]) begin
      res = sum[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
    end else begin
      res = sum[VAL_W-1:0];
    end
    return res;
  endfunction

  // Control
  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    scan_idx_r, scan_idx_nxt;
  logic [IDX_W-1:0]    chk_idx_r, chk_idx_nxt;
  logic                pend_r, pend_nxt;
  logic                out_valid_r, out_valid_nxt;

  // Request held during the scan
  krt_pkg::kind_t           kind_r, kind_nxt;
  logic signed [KEY_W-1:0]  key_r, key_nxt;
  logic signed [VAL_W-1:0]  price_r, price_nxt;
  logic signed [VAL_W-1:0]  qty_r, qty_nxt;

  // Result being built, then the output register
  krt_pkg::status_t         res_status_r, res_status_nxt;
  logic [IDX_W-1:0]         res_idx_r, res_idx_nxt;
  logic signed [VAL_W-1:0]  res_price_r, res_price_nxt;
  logic signed [VAL_W-1:0]  res_qty_r, res_qty_nxt;

  krt_pkg::status_t         out_status_r, out_status_nxt;
  logic [SLOT_W-1:0]        out_slot_r, out_slot_nxt;
  logic signed [VAL_W-1:0]  out_price_r, out_price_nxt;
  logic signed [VAL_W-1:0]  out_qty_r, out_qty_nxt;

  // Memory ports
  logic                     key_we, data_we;
  logic [IDX_W-1:0]         waddr, raddr;
  logic [KEY_W-1:0]         key_rdata;
  logic [2*VAL_W-1:0]       data_wdata, data_rdata;
  logic                     match;
  logic signed [VAL_W-1:0]  upd_qty;
  logic [IDX_W+SLOT_W-1:0]  idx_wide;

  // Keys live in one memory, price and quantity side by side in the other;
  // both are read at the same scan address so a hit has its record at once.
  krt_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_DEPTH)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (waddr),
    .wdata (key_r),
    .raddr (raddr),
    .rdata (key_rdata)
  );

  krt_ram #(.WIDTH(2*VAL_W), .DEPTH(TABLE_DEPTH)) u_data_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr (waddr),
    .wdata (data_wdata),
    .raddr (raddr),
    .rdata (data_rdata)
  );

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.slot        = out_slot_r;
  assign out_ch.found_price = out_price_r;
  assign out_ch.found_qty   = out_qty_r;

  assign raddr    = scan_idx_r[IDX_W-1:0];
  assign match    = pend_r && (key_rdata == key_r);
  assign upd_qty  = sat_add(res_qty_r, qty_r);
  assign idx_wide = {{SLOT_W{1'b0}}, res_idx_r};

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    scan_idx_nxt   = scan_idx_r;
    chk_idx_nxt    = chk_idx_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = out_valid_r;
    kind_nxt       = kind_r;
    key_nxt        = key_r;
    price_nxt      = price_r;
    qty_nxt        = qty_r;
    res_status_nxt = res_status_r;
    res_idx_nxt    = res_idx_r;
    res_price_nxt  = res_price_r;
    res_qty_nxt    = res_qty_r;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_price_nxt  = out_price_r;
    out_qty_nxt    = out_qty_r;
    key_we         = 1'b0;
    data_we        = 1'b0;
    waddr          = count_r[IDX_W-1:0];
    data_wdata     = {price_r, qty_r};

    // Drop the held result once it is taken; a new one may replace it below.
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          kind_nxt     = in_ch.kind;
          key_nxt      = in_ch.part_key;
          price_nxt    = in_ch.new_price;
          qty_nxt      = in_ch.qty_value;
          scan_idx_nxt = '0;
          pend_nxt     = 1'b0;
          res_idx_nxt  = '0;
          res_price_nxt = '0;
          res_qty_nxt  = '0;
          // A full table rejects an insert before any key is checked.
          if (in_ch.kind == krt_pkg::KIND_INSERT && count_r == CNT_W'(TABLE_DEPTH)) begin
            res_status_nxt = krt_pkg::ST_FULL;
            state_nxt      = S_DONE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (match) begin
          // First match wins: stop the scan here.
          pend_nxt = 1'b0;
          if (kind_r == krt_pkg::KIND_INSERT) begin
            res_status_nxt = krt_pkg::ST_EXISTS;
            state_nxt      = S_DONE;
          end else begin
            res_status_nxt = krt_pkg::ST_OK;
            res_idx_nxt    = chk_idx_r;
            res_price_nxt  = data_rdata[2*VAL_W-1:VAL_W];
            res_qty_nxt    = data_rdata[VAL_W-1:0];
            state_nxt      = (kind_r == krt_pkg::KIND_UPDATE) ? S_UPD : S_DONE;
          end
        end else if (!pend_r && scan_idx_r == count_r) begin
          // Every filled entry checked without a hit.
          if (kind_r == krt_pkg::KIND_INSERT) begin
            key_we         = 1'b1;
            data_we        = 1'b1;
            res_status_nxt = krt_pkg::ST_OK;
            res_idx_nxt    = count_r[IDX_W-1:0];
            res_price_nxt  = price_r;
            res_qty_nxt    = qty_r;
            count_nxt      = count_r + CNT_W'(1);
          end else begin
            res_status_nxt = krt_pkg::ST_MISSING;
          end
          state_nxt = S_DONE;
        end else if (scan_idx_r != count_r) begin
          // Issue the next key read; its data is compared next cycle.
          pend_nxt     = 1'b1;
          chk_idx_nxt  = scan_idx_r[IDX_W-1:0];
          scan_idx_nxt = scan_idx_r + CNT_W'(1);
        end else begin
          pend_nxt = 1'b0;
        end
      end

      S_UPD: begin
        // Write back the clamped quantity; the next read is a whole item away.
        data_we     = 1'b1;
        waddr       = res_idx_r;
        data_wdata  = {res_price_r, upd_qty};
        res_qty_nxt = upd_qty;
        state_nxt   = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_slot_nxt   = idx_wide[SLOT_W-1:0];
          out_price_nxt  = res_price_r;
          out_qty_nxt    = res_qty_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_idx_r   <= scan_idx_nxt;
    chk_idx_r    <= chk_idx_nxt;
    kind_r       <= kind_nxt;
    key_r        <= key_nxt;
    price_r      <= price_nxt;
    qty_r        <= qty_nxt;
    res_status_r <= res_status_nxt;
    res_idx_r    <= res_idx_nxt;
    res_price_r  <= res_price_nxt;
    res_qty_r    <= res_qty_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_price_r  <= out_price_nxt;
    out_qty_r    <= out_qty_nxt;
  end

endmodule

/* src/krt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module krt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sim/krt_checker.sv */
// Checker for the keyed record table: watches both channels, predicts and compares.
`timescale 1ns / 1ps

module krt_checker (
  input  logic clk,
  input  logic rst_n,
  krt_req_if   req,
  krt_rsp_if   rsp,
  output int   mismatches,
  output int   outstanding
);
  import krt_pkg::*;

  localparam int DEPTH = TABLE_DEPTH_DEF;
  localparam int NO_SLOT = -1;
  localparam logic signed [VAL_W-1:0] QTY_MAX = 32'sh7fff_ffff;
  localparam logic signed [VAL_W-1:0] QTY_MIN = 32'sh8000_0000;

  typedef struct packed {
    status_t                   status;
    logic [SLOT_W-1:0]         slot;
    logic signed [VAL_W-1:0]   price;
    logic signed [VAL_W-1:0]   qty;
  } lookup_reply_t;

  lookup_reply_t           reply_q[$];
  logic [KEY_W-1:0]        part_keys [DEPTH];
  logic signed [VAL_W-1:0] part_prices [DEPTH];
  logic signed [VAL_W-1:0] part_qtys [DEPTH];
  int                      filled;
  int                      results_seen;

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  function automatic int locate_key(logic [KEY_W-1:0] key);
    for (int i = 0; i < filled; i++) begin
      if (part_keys[i] == key) return i;
    end
    return NO_SLOT;
  endfunction

  function automatic logic signed [VAL_W-1:0] add_clamped(logic signed [VAL_W-1:0] a,
                                                          logic signed [VAL_W-1:0] b);
    longint sum;
    sum = longint'(a) + longint'(b);
    if (sum > longint'(QTY_MAX)) return QTY_MAX;
    if (sum < longint'(QTY_MIN)) return QTY_MIN;
    return sum[VAL_W-1:0];
  endfunction

  // Apply one request to the table copy and build the reply it should produce.
  task automatic serve_request(input kind_t kind, input logic [KEY_W-1:0] key,
                               input logic signed [VAL_W-1:0] price,
                               input logic signed [VAL_W-1:0] qty,
                               output lookup_reply_t r);
    int idx;
    r = '{status: ST_OK, slot: '0, price: '0, qty: '0};
    if (kind == KIND_INSERT) begin
      if (filled >= DEPTH) begin
        r.status = ST_FULL;
      end else if (locate_key(key) != NO_SLOT) begin
        r.status = ST_EXISTS;
      end else begin
        part_keys[filled]   = key;
        part_prices[filled] = price;
        part_qtys[filled]   = qty;
        r.slot  = filled[SLOT_W-1:0];
        r.price = price;
        r.qty   = qty;
        filled++;
      end
    end else begin
      idx = locate_key(key);
      if (idx == NO_SLOT) begin
        r.status = ST_MISSING;
      end else begin
        if (kind == KIND_UPDATE) part_qtys[idx] = add_clamped(part_qtys[idx], qty);
        r.slot  = idx[SLOT_W-1:0];
        r.price = part_prices[idx];
        r.qty   = part_qtys[idx];
      end
    end
  endtask

  task automatic report_mismatch(input string field, input logic [VAL_W-1:0] want,
                                 input logic [VAL_W-1:0] got);
    mismatches++;
    if (mismatches <= 40)
      $display("mismatch in result %0d, %s: expected %0h, got %0h",
               results_seen, field, want, got);
  endtask

  always @(posedge clk) begin
    lookup_reply_t want;
    if (!rst_n) begin
      filled       = 0;
      results_seen = 0;
      reply_q.delete();
    end else begin
      // Check the result first: it never belongs to a request taken on this edge.
      if (rsp.valid && rsp.ready) begin
        if (reply_q.size() == 0) begin
          report_mismatch("result with no request waiting", '0, {30'd0, rsp.status});
        end else begin
          want = reply_q.pop_front();
          if (rsp.status !== want.status)
            report_mismatch("status", {30'd0, want.status}, {30'd0, rsp.status});
          if (rsp.slot !== want.slot)
            report_mismatch("slot", {26'd0, want.slot}, {26'd0, rsp.slot});
          if (rsp.found_price !== want.price)
            report_mismatch("found_price", want.price, rsp.found_price);
          if (rsp.found_qty !== want.qty)
            report_mismatch("found_qty", want.qty, rsp.found_qty);
        end
        results_seen++;
      end
      if (req.valid && req.ready) begin
        serve_request(req.kind, req.part_key, req.new_price, req.qty_value, want);
        reply_q.push_back(want);
      end
    end
    outstanding <= reply_q.size();
  end

endmodule

/* sim/testbench.sv */
// Top of the keyed record table testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
  import krt_pkg::*;

  localparam int RANDOM_ITEMS = 850;
  localparam int DRAIN_CYCLES = 100;     // well past the longest scan of a full table
  localparam int CYCLE_LIMIT  = 400000;  // several times the slowest correct run

  localparam kind_t KIND_UNUSED = 2'd3;  // behaves as a search

  localparam logic [KEY_W-1:0] WORD_MIN  = 32'h8000_0000;
  localparam logic [KEY_W-1:0] WORD_MAX  = 32'h7fff_ffff;
  localparam logic [KEY_W-1:0] WORD_ZERO = 32'h0000_0000;
  localparam logic [KEY_W-1:0] WORD_ONES = 32'hffff_ffff;
  localparam logic [KEY_W-1:0] WORD_ONE  = 32'h0000_0001;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   results_due;
  int   cycle_count;
  int   tx_idle_pct;
  int   rx_idle_pct;

  // Keys offered on inserts; searches and updates mostly draw from here to hit.
  logic [KEY_W-1:0] key_pool[$];

  krt_req_if in_ch();
  krt_rsp_if out_ch();

  keyed_record_table i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  krt_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req         (in_ch),
    .rsp         (out_ch),
    .mismatches  (fail_count),
    .outstanding (results_due)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Stall the result channel at random; a zero percentage keeps ready high.
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Stop a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Drive one item at a falling edge, after random idle cycles, and hold it until
  // taken. Leave valid high on return so back-to-back items never drop it.
  task automatic send_item(input kind_t kind, input logic [KEY_W-1:0] key,
                           input logic [VAL_W-1:0] price, input logic [VAL_W-1:0] qty);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.kind      <= kind;
    in_ch.part_key  <= key;
    in_ch.new_price <= price;
    in_ch.qty_value <= qty;
    if (kind == KIND_INSERT) key_pool.push_back(key);
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Drop valid and hold off until every result has come back.
  task automatic hold_until_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    wait (results_due == 0);
  endtask

  function automatic logic [VAL_W-1:0] extreme_word();
    case ($urandom_range(4))
      0:       return WORD_MIN;
      1:       return WORD_MAX;
      2:       return WORD_ZERO;
      3:       return WORD_ONES;
      default: return WORD_ONE;
    endcase
  endfunction

  function automatic logic [KEY_W-1:0] pooled_key();
    if (key_pool.size() == 0) return $urandom();
    return key_pool[$urandom_range(key_pool.size() - 1)];
  endfunction

  // Pick a key: inserts lean on fresh keys, lookups lean on known ones.
  function automatic logic [KEY_W-1:0] pick_key(input kind_t kind);
    int r;
    r = $urandom_range(99);
    if (r < 10) return extreme_word();
    if (kind == KIND_INSERT) return (r < 25) ? pooled_key() : $urandom();
    return (r < 85) ? pooled_key() : $urandom();
  endfunction

  // Updates mix small steps with wide and extreme ones to reach both clamps.
  function automatic logic [VAL_W-1:0] pick_change();
    int r;
    r = $urandom_range(99);
    if (r < 40) return $urandom_range(2000) - 1000;
    if (r < 70) return $urandom();
    return extreme_word();
  endfunction

  task automatic send_random_item();
    kind_t            kind;
    int               r;
    logic [VAL_W-1:0] qty;
    r = $urandom_range(99);
    if (r < 25)      kind = KIND_INSERT;
    else if (r < 55) kind = KIND_SEARCH;
    else if (r < 94) kind = KIND_UPDATE;
    else             kind = KIND_UNUSED;
    qty = (kind == KIND_INSERT && r < 20) ? $urandom() : pick_change();
    send_item(kind, pick_key(kind), ($urandom_range(9) == 0) ? extreme_word() : $urandom(),
              qty);
  endtask

  initial begin
    // Drive every input to a known value before the first edge.
    rst_n           = 1'b0;
    cycle_count     = 0;
    tx_idle_pct     = 17;
    rx_idle_pct     = 57;
    in_ch.valid     = 1'b0;
    in_ch.kind      = KIND_SEARCH;
    in_ch.part_key  = '0;
    in_ch.new_price = '0;
    in_ch.qty_value = '0;
    out_ch.ready    = 1'b0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Lookups on an empty table all miss, the unused kind included.
    send_item(KIND_SEARCH, WORD_ZERO, WORD_ONE, WORD_ONE);
    send_item(KIND_UPDATE, WORD_ONES, WORD_ZERO, WORD_ONE);
    send_item(KIND_UNUSED, WORD_ONE, WORD_ZERO, WORD_ZERO);
    // Fill with extreme keys, prices and quantities.
    send_item(KIND_INSERT, WORD_MIN, WORD_MAX, WORD_MAX);
    send_item(KIND_INSERT, WORD_MAX, WORD_MIN, WORD_MIN);
    send_item(KIND_INSERT, WORD_ZERO, WORD_ZERO, WORD_ZERO);
    send_item(KIND_INSERT, WORD_ONES, WORD_ONES, WORD_ONES);
    // Reject a duplicate key.
    send_item(KIND_INSERT, WORD_MIN, WORD_ONE, WORD_ONE);
    send_item(KIND_SEARCH, WORD_MAX, WORD_ZERO, WORD_ZERO);
    send_item(KIND_UNUSED, WORD_ZERO, WORD_ONE, WORD_ONE);
    // Clamp at the top and bottom, then step back inside the range.
    send_item(KIND_UPDATE, WORD_MIN, WORD_ZERO, WORD_ONE);
    send_item(KIND_UPDATE, WORD_MAX, WORD_ZERO, WORD_ONES);
    send_item(KIND_UPDATE, WORD_MIN, WORD_ZERO, WORD_MIN);
    send_item(KIND_UPDATE, WORD_ZERO, WORD_ZERO, WORD_MAX);
    send_item(KIND_UPDATE, WORD_ZERO, WORD_ZERO, WORD_ONE);
    send_item(KIND_UPDATE, WORD_ONES, WORD_ZERO, WORD_MIN);
    send_item(KIND_UPDATE, WORD_ONES, WORD_ZERO, WORD_ZERO);
    // Miss on a key never inserted.
    send_item(KIND_SEARCH, 32'd12345, WORD_ZERO, WORD_ZERO);
    send_item(KIND_UPDATE, 32'd12345, WORD_ZERO, WORD_ONE);
    send_item(KIND_SEARCH, WORD_ONES, WORD_ZERO, WORD_ZERO);

    // Random part in three idling phases; drain the pipe between phases.
    for (int phase = 0; phase < 3; phase++) begin
      hold_until_drained();
      case (phase)
        0: begin
          tx_idle_pct = 17;
          rx_idle_pct = 57;
        end
        1: begin
          tx_idle_pct = 57;
          rx_idle_pct = 17;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      for (int n = 0; n < RANDOM_ITEMS / 3; n++) send_random_item();
    end

    // Drain, give the block time for a stray result, then judge.
    @(negedge clk);
    in_ch.valid <= 1'b0;
    wait (results_due == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && results_due == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
